@@ hdl/glmc_pkg.sv @@
package glmc_pkg;

   localparam int VALUE_WIDTH = 16;
   localparam int MAX_COLUMNS = 1024;
   localparam int MAX_ROWS = 1024;
   localparam int SIZE_WIDTH = 11;
   localparam int TOTAL_WIDTH = 20;
   localparam int COL_WIDTH = $clog2(MAX_COLUMNS);
   localparam int ROW_WIDTH = $clog2(MAX_ROWS);
   localparam int ENTRY_WIDTH = VALUE_WIDTH + 1;

   typedef enum logic [0:0] {
      CSR_ROW_COUNT    = 1'b0,
      CSR_COLUMN_COUNT = 1'b1
   } csr_index_type;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;

   // position flags of the request held in the compare stage
   typedef struct packed {
      logic                 valid;
      logic [COL_WIDTH-1:0] column;
      logic                 has_up;
      logic                 last_row;
      logic                 last_col;
   } stage_type;

   function automatic logic [SIZE_WIDTH-1:0] clamp_size(
      input logic [SIZE_WIDTH-1:0] value,
      input logic [SIZE_WIDTH-1:0] limit
   );
      logic [SIZE_WIDTH-1:0] result;
      result = value;
      if (value == '0) begin
         result = SIZE_WIDTH'(1);
      end else if (value > limit) begin
         result = limit;
      end
      return result;
   endfunction

endpackage

@@ hdl/glmc_req_if.sv @@
interface glmc_req_if
   import glmc_pkg::*;
();
   logic      valid;
   logic      ready;
   value_type element_value;

   modport source (output valid, output element_value, input ready);
   modport sink (input valid, input element_value, output ready);
endinterface

@@ hdl/glmc_rsp_if.sv @@
interface glmc_rsp_if
   import glmc_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [TOTAL_WIDTH-1:0] minimum_total;

   modport source (output valid, output minimum_total, input ready);
   modport sink (input valid, input minimum_total, output ready);
endinterface

@@ hdl/grid_local_minimum_counter_unit.sv @@
// Counts strict 4-neighbour local minima of a signed matrix streamed in
// raster order, one element per request on req_bus (valid/ready).
// The matrix size comes from the csr port: index 0 sets the row count,
// index 1 the column count; zero acts as 1, larger than 1024 as 1024.
// A csr write restarts the matrix; write only while the block is idle.
// After the last element one response on rsp_bus carries the total.
// Throughput: one request per cycle unless the compare stage is held,
// set by the single read and single write of the line buffer RAM each
// request uses; the total reaches rsp_bus through the output register.
// The response waits in an output register; further requests are still
// taken while it waits. Only a second total arriving while the first is
// unclaimed holds the compare stage, and then req_bus.ready drops.
// Reset (synchronous, active high) sets both sizes to 1, clears the
// position and total, and empties the pipeline; the line buffer needs no
// clearing since every entry is written on a row before it is read.
module grid_local_minimum_counter_unit
   import glmc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   glmc_req_if.sink               req_bus,
   glmc_rsp_if.source             rsp_bus,
   input  logic                   csr_write_enable,
   input  csr_index_type          csr_index,
   input  logic [SIZE_WIDTH-1:0]  csr_write_data
);

   localparam logic [SIZE_WIDTH-1:0] ROW_LIMIT = SIZE_WIDTH'(MAX_ROWS);
   localparam logic [SIZE_WIDTH-1:0] COL_LIMIT = SIZE_WIDTH'(MAX_COLUMNS);

   logic [SIZE_WIDTH-1:0]  row_count_ff, row_count_in;
   logic [SIZE_WIDTH-1:0]  column_count_ff, column_count_in;
   logic [ROW_WIDTH-1:0]   row_ff, row_in;
   logic [COL_WIDTH-1:0]   col_ff, col_in;
   stage_type              stage_ff, stage_in;
   value_type              cur_ff, cur_in;
   logic                   byp_hit_ff, byp_hit_in;
   logic [ENTRY_WIDTH-1:0] byp_data_ff, byp_data_in;
   value_type              left_value_ff, left_value_in;
   logic                   left_pending_ff, left_pending_in;
   value_type              edge_value_ff, edge_value_in;
   logic                   edge_pending_ff, edge_pending_in;
   logic [TOTAL_WIDTH-1:0] total_ff, total_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_WIDTH-1:0] rsp_total_ff, rsp_total_in;

   logic                   accept;
   logic                   acc_last_col;
   logic                   acc_last_row;
   logic                   stage_final;
   logic                   stage_stall;
   logic                   stage_fire;
   logic                   has_left;
   logic [ENTRY_WIDTH-1:0] ram_q;
   logic [ENTRY_WIDTH-1:0] up_entry;
   value_type              up_value;
   logic                   up_pending;
   logic                   up_less;
   logic                   cur_below_up;
   logic                   cur_below_left;
   logic                   left_done;
   logic                   mine;
   logic [1:0]             inc;
   logic [TOTAL_WIDTH:0]   total_sum;
   logic [TOTAL_WIDTH-1:0] total_next;
   logic                   wr_en;
   logic [COL_WIDTH-1:0]   wr_addr;
   logic [ENTRY_WIDTH-1:0] wr_data;

   // compare stage
   assign stage_final = stage_ff.last_row & stage_ff.last_col;
   assign stage_stall = stage_ff.valid & stage_final & rsp_valid_ff & ~rsp_bus.ready;
   assign stage_fire = stage_ff.valid & ~stage_stall;
   assign req_bus.ready = ~stage_ff.valid | stage_fire;
   assign accept = req_bus.valid & req_bus.ready;

   assign acc_last_col = ({1'b0, col_ff} + SIZE_WIDTH'(1)) >= column_count_ff;
   assign acc_last_row = ({1'b0, row_ff} + SIZE_WIDTH'(1)) >= row_count_ff;

   assign has_left = stage_ff.column != '0;

   // last column lives in a register, the ram holds the others
   always_comb begin
      if (stage_ff.last_col) begin
         up_entry = {edge_pending_ff, edge_value_ff};
      end else if (byp_hit_ff) begin
         up_entry = byp_data_ff;
      end else begin
         up_entry = ram_q;
      end
   end

   assign up_value = value_type'(up_entry[VALUE_WIDTH-1:0]);
   assign up_pending = up_entry[VALUE_WIDTH];
   assign up_less = up_value < cur_ff;
   assign cur_below_up = cur_ff < up_value;
   assign cur_below_left = cur_ff < left_value_ff;
   assign left_done = left_pending_ff & (left_value_ff < cur_ff);
   assign mine = (~stage_ff.has_up | cur_below_up) & (~has_left | cur_below_left);

   assign inc = 2'(stage_ff.has_up & up_pending & up_less)
              + 2'(has_left & stage_ff.last_row & left_done)
              + 2'(stage_final & mine);

   assign total_sum = {1'b0, total_ff} + (TOTAL_WIDTH + 1)'(inc);
   assign total_next = total_sum[TOTAL_WIDTH] ? '1 : total_sum[TOTAL_WIDTH-1:0];

   // left neighbour is settled now that its right neighbour is here
   assign wr_en = stage_fire & has_left;
   assign wr_addr = stage_ff.column - COL_WIDTH'(1);
   assign wr_data = {left_done, left_value_ff};

   glmc_line_ram #(
      .DEPTH (MAX_COLUMNS),
      .WIDTH (ENTRY_WIDTH)
   ) u_line_ram (
      .clock         (clock),
      .write_enable  (wr_en),
      .write_address (wr_addr),
      .write_data    (wr_data),
      .read_enable   (accept),
      .read_address  (col_ff),
      .read_data     (ram_q)
   );

   always_comb begin
      row_count_in = row_count_ff;
      column_count_in = column_count_ff;
      row_in = row_ff;
      col_in = col_ff;
      stage_in = stage_ff;
      cur_in = cur_ff;
      byp_hit_in = byp_hit_ff;
      byp_data_in = byp_data_ff;
      left_value_in = left_value_ff;
      left_pending_in = left_pending_ff;
      edge_value_in = edge_value_ff;
      edge_pending_in = edge_pending_ff;
      total_in = total_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_total_in = rsp_total_ff;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (stage_fire) begin
         stage_in.valid = 1'b0;
         if (stage_ff.last_col) begin
            left_value_in = '0;
            left_pending_in = 1'b0;
            edge_value_in = cur_ff;
            edge_pending_in = mine;
         end else begin
            left_value_in = cur_ff;
            left_pending_in = mine;
         end
         if (stage_final) begin
            total_in = '0;
            rsp_valid_in = 1'b1;
            rsp_total_in = total_next;
         end else begin
            total_in = total_next;
         end
      end

      if (accept) begin
         stage_in.valid = 1'b1;
         stage_in.column = col_ff;
         stage_in.has_up = row_ff != '0;
         stage_in.last_row = acc_last_row;
         stage_in.last_col = acc_last_col;
         cur_in = req_bus.element_value;
         // write to the entry being read this cycle
         byp_hit_in = wr_en & (wr_addr == col_ff);
         byp_data_in = wr_data;
         if (acc_last_col) begin
            col_in = '0;
            row_in = acc_last_row ? '0 : row_ff + ROW_WIDTH'(1);
         end else begin
            col_in = col_ff + COL_WIDTH'(1);
         end
      end

      if (csr_write_enable) begin
         case (csr_index)
            CSR_ROW_COUNT: begin
               row_count_in = clamp_size(csr_write_data, ROW_LIMIT);
            end
            CSR_COLUMN_COUNT: begin
               column_count_in = clamp_size(csr_write_data, COL_LIMIT);
            end
            default: begin
               row_count_in = row_count_ff;
            end
         endcase
         row_in = '0;
         col_in = '0;
         total_in = '0;
         left_value_in = '0;
         left_pending_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= SIZE_WIDTH'(1);
         column_count_ff <= SIZE_WIDTH'(1);
         row_ff <= '0;
         col_ff <= '0;
         stage_ff <= '0;
         byp_hit_ff <= 1'b0;
         left_pending_ff <= 1'b0;
         total_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_count_ff <= row_count_in;
         column_count_ff <= column_count_in;
         row_ff <= row_in;
         col_ff <= col_in;
         stage_ff <= stage_in;
         byp_hit_ff <= byp_hit_in;
         left_pending_ff <= left_pending_in;
         total_ff <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      byp_data_ff <= byp_data_in;
      left_value_ff <= left_value_in;
      edge_value_ff <= edge_value_in;
      edge_pending_ff <= edge_pending_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.minimum_total = rsp_total_ff;

endmodule

@@ hdl/glmc_line_ram.sv @@
module glmc_line_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 17
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_enable,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_address] <= write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (read_enable) begin
         read_data_ff <= mem[read_address];
      end
   end

   assign read_data = read_data_ff;

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import glmc_pkg::*;

   localparam value_type MOST_NEGATIVE = 16'sh8000;
   localparam value_type MOST_POSITIVE = 16'sh7FFF;
   localparam logic [TOTAL_WIDTH-1:0] TOTAL_LIMIT = '1;
   localparam int SETTLE_CYCLES = 4;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int RANDOM_ITEMS = 900;

   typedef struct packed {
      logic                   is_csr;
      csr_index_type          index;
      logic [SIZE_WIDTH-1:0]  data;
      value_type              element;
      logic                   has_total;
      logic [TOTAL_WIDTH-1:0] total;
   } script_row_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   csr_index_type csr_index;
   logic [SIZE_WIDTH-1:0] csr_write_data;

   glmc_req_if req_bus ();
   glmc_rsp_if rsp_bus ();

   grid_local_minimum_counter_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // shadow of the block's line buffer and scan position
   value_type              prior_row_values [MAX_COLUMNS];
   bit                     prior_row_waiting [MAX_COLUMNS];
   value_type              left_cell_value;
   bit                     left_cell_waiting;
   int                     scan_row;
   int                     scan_col;
   logic [TOTAL_WIDTH-1:0] minima_found;
   int                     size_rows;
   int                     size_cols;

   logic [TOTAL_WIDTH-1:0] expected_totals [$];
   int                     error_count;
   bit                     steady_run;
   bit                     calm_phase;
   bit                     long_hold_request;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic void restart_scan();
      left_cell_value = '0;
      left_cell_waiting = 1'b0;
      scan_row = 0;
      scan_col = 0;
      minima_found = '0;
   endfunction

   function automatic void add_minimum();
      if (minima_found < TOTAL_LIMIT) begin
         minima_found = minima_found + 1'b1;
      end
   endfunction

   // one raster step; a cell is settled once its right and down neighbours are seen
   function automatic bit count_minima_step(input value_type cur,
                                            output logic [TOTAL_WIDTH-1:0] total_out);
      int  r;
      int  c;
      bit  last_row;
      bit  last_col;
      bit  is_min;
      bit  left_done;
      r = scan_row;
      c = scan_col;
      last_row = (r + 1 >= size_rows);
      last_col = (c + 1 >= size_cols);
      is_min = 1'b1;
      total_out = '0;
      if (r > 0) begin
         if (prior_row_waiting[c] && prior_row_values[c] < cur) begin
            add_minimum();
         end
         if (!(cur < prior_row_values[c])) begin
            is_min = 1'b0;
         end
      end
      if (c > 0) begin
         left_done = left_cell_waiting && (left_cell_value < cur);
         if (!(cur < left_cell_value)) begin
            is_min = 1'b0;
         end
         if (last_row) begin
            if (left_done) begin
               add_minimum();
            end
         end else begin
            prior_row_waiting[c-1] = left_done;
         end
      end
      prior_row_values[c] = cur;
      if (last_col) begin
         if (last_row) begin
            if (is_min) begin
               add_minimum();
            end
         end else begin
            prior_row_waiting[c] = is_min;
         end
         left_cell_value = '0;
         left_cell_waiting = 1'b0;
      end else begin
         left_cell_value = cur;
         left_cell_waiting = is_min;
      end
      c++;
      if (c >= size_cols) begin
         c = 0;
         r++;
      end
      if (r >= size_rows) begin
         total_out = minima_found;
         restart_scan();
         return 1'b1;
      end
      scan_row = r;
      scan_col = c;
      return 1'b0;
   endfunction

   function automatic value_type draw_element(input int mode);
      int raw;
      case (mode)
         0: raw = $urandom_range(0, 65535) - 32768;
         1: raw = $urandom_range(0, 6) - 3;
         2: begin
            case ($urandom_range(0, 3))
               0: raw = -32768;
               1: raw = 32767;
               2: raw = 0;
               default: raw = -1;
            endcase
         end
         default: raw = $urandom_range(0, 200) - 100;
      endcase
      return value_type'(raw);
   endfunction

   task automatic flag_error(input string what, input logic [TOTAL_WIDTH-1:0] want,
                             input logic [TOTAL_WIDTH-1:0] got);
      error_count++;
      if (error_count <= 10) begin
         $display("ERROR %s: expected %0d, got %0d", what, want, got);
      end
   endtask

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_element(input value_type cur, input bit has_total,
                               input logic [TOTAL_WIDTH-1:0] fixed_total);
      logic [TOTAL_WIDTH-1:0] predicted;
      bit                     done;
      int                     gap;
      if (!steady_run && !calm_phase && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 4);
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.element_value = cur;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      done = count_minima_step(cur, predicted);
      if (has_total) begin
         expected_totals.push_back(fixed_total);
      end else if (done) begin
         expected_totals.push_back(predicted);
      end
      @(negedge clock);
   endtask

   // size writes only once the block has drained
   task automatic write_size(input csr_index_type index, input logic [SIZE_WIDTH-1:0] data);
      int size;
      req_bus.valid = 1'b0;
      while (expected_totals.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = index;
      csr_write_data = data;
      @(posedge clock);
      if (data == '0) begin
         size = 1;
      end else if (data > MAX_ROWS) begin
         size = MAX_ROWS;
      end else begin
         size = data;
      end
      if (index == CSR_ROW_COUNT) begin
         size_rows = size;
      end else begin
         size_cols = size;
      end
      restart_scan();
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic send_matrix(input int mode);
      int k;
      for (k = 0; k < size_rows * size_cols; k++) begin
         send_element(draw_element(mode), 1'b0, '0);
      end
   endtask

   // response side: random stalls plus one long hold on request
   initial begin : response_side
      int burst;
      int hold_left;
      bit hold_taken;
      burst = 0;
      hold_left = 0;
      hold_taken = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_request && !hold_taken) begin
            hold_left = LONG_HOLD_CYCLES;
            hold_taken = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready = 1'b0;
         end else if (steady_run || calm_phase) begin
            burst = 0;
            rsp_bus.ready = 1'b1;
         end else if (burst > 0) begin
            burst--;
            rsp_bus.ready = 1'b0;
         end else if ($urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 4) - 1;
            rsp_bus.ready = 1'b0;
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_totals.size() == 0) begin
            flag_error("response with no request pending", '0, rsp_bus.minimum_total);
         end else if (rsp_bus.minimum_total !== expected_totals[0]) begin
            flag_error("minimum total", expected_totals[0], rsp_bus.minimum_total);
            void'(expected_totals.pop_front());
         end else begin
            void'(expected_totals.pop_front());
         end
      end
   end

   initial begin : stimulus
      script_row_type directed_script [33];
      int random_items;
      int phase_matrices;
      int partial;
      int mode;
      int m;
      int k;
      int drain_wait;
      logic [SIZE_WIDTH-1:0] rows_data;
      logic [SIZE_WIDTH-1:0] cols_data;

      directed_script = '{
         // 1x1 after reset: the single cell always counts
         '{1'b0, CSR_ROW_COUNT, 11'd0, 16'sd0, 1'b1, 20'd1},
         '{1'b0, CSR_ROW_COUNT, 11'd0, MOST_NEGATIVE, 1'b1, 20'd1},
         '{1'b0, CSR_ROW_COUNT, 11'd0, MOST_POSITIVE, 1'b1, 20'd1},
         // zero sizes act as one
         '{1'b1, CSR_ROW_COUNT, 11'd0, 16'sd0, 1'b0, 20'd0},
         '{1'b1, CSR_COLUMN_COUNT, 11'd0, 16'sd0, 1'b0, 20'd0},
         '{1'b0, CSR_ROW_COUNT, 11'd0, 16'sd5, 1'b1, 20'd1},
         // one row, two columns: ties never count
         '{1'b1, CSR_COLUMN_COUNT, 11'd2, 16'sd0, 1'b0, 20'd0},
         '{1'b0, CSR_ROW_COUNT, 11'd0, 16'sd5, 1'b0, 20'd0},
         '{1'b0, CSR_ROW_COUNT, 11'd0, 16'sd5, 1'b1, 20'd0},
         '{1'b0, CSR_ROW_COUNT, 11'd0, MOST_NEGATIVE, 1'b0, 20'd0},
         '{1'b0, CSR_ROW_COUNT, 11'd0, MOST_POSITIVE, 1'b1, 20'd1},
         // full size, then abandoned by a row write mid-matrix
         '{1'b1, CSR_ROW_COUNT, 11'd1024, 16'sd0, 1'b0, 20'd0},
         '{1'b1, CSR_COLUMN_COUNT, 11'd1024, 16'sd0, 1'b0, 20'd0},
         '{1'b0, CSR_ROW_COUNT, 11'd0, 16'sd1, 1'b0, 20'd0},
         '{1'b0, CSR_ROW_COUNT, 11'd0, 16'sd2, 1'b0, 20'd0},
         '{1'b0, CSR_ROW_COUNT, 11'd0, 16'sd3, 1'b0, 20'd0},
         '{1'b1, CSR_ROW_COUNT, 11'd2, 16'sd0, 1'b0, 20'd0},
         '{1'b1, CSR_COLUMN_COUNT, 11'd2, 16'sd0, 1'b0, 20'd0},
         // 2x2 with the corner minimum at the top left
         '{1'b0, CSR_ROW_COUNT, 11'd0, 16'sd1, 1'b0, 20'd0},
         '{1'b0, CSR_ROW_COUNT, 11'd0, 16'sd2, 1'b0, 20'd0},
         '{1'b0, CSR_ROW_COUNT, 11'd0, 16'sd3, 1'b0, 20'd0},
         '{1'b0, CSR_ROW_COUNT, 11'd0, 16'sd4, 1'b1, 20'd1},
         // 3x3 with only the center strictly lowest
         '{1'b1, CSR_ROW_COUNT, 11'd3, 16'sd0, 1'b0, 20'd0},
         '{1'b1, CSR_COLUMN_COUNT, 11'd3, 16'sd0, 1'b0, 20'd0},
         '{1'b0, CSR_ROW_COUNT, 11'd0, 16'sd9, 1'b0, 20'd0},
         '{1'b0, CSR_ROW_COUNT, 11'd0, 16'sd9, 1'b0, 20'd0},
         '{1'b0, CSR_ROW_COUNT, 11'd0, 16'sd9, 1'b0, 20'd0},
         '{1'b0, CSR_ROW_COUNT, 11'd0, 16'sd9, 1'b0, 20'd0},
         '{1'b0, CSR_ROW_COUNT, 11'd0, 16'sd0, 1'b0, 20'd0},
         '{1'b0, CSR_ROW_COUNT, 11'd0, 16'sd9, 1'b0, 20'd0},
         '{1'b0, CSR_ROW_COUNT, 11'd0, 16'sd9, 1'b0, 20'd0},
         '{1'b0, CSR_ROW_COUNT, 11'd0, 16'sd9, 1'b0, 20'd0},
         '{1'b0, CSR_ROW_COUNT, 11'd0, 16'sd9, 1'b1, 20'd1}
      };

      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.element_value = '0;
      csr_write_enable = 1'b0;
      csr_index = CSR_ROW_COUNT;
      csr_write_data = '0;
      error_count = 0;
      steady_run = 1'b0;
      calm_phase = 1'b0;
      long_hold_request = 1'b0;
      size_rows = 1;
      size_cols = 1;
      restart_scan();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_script[i]) begin
         if (directed_script[i].is_csr) begin
            write_size(directed_script[i].index, directed_script[i].data);
         end else begin
            send_element(directed_script[i].element, directed_script[i].has_total,
                         directed_script[i].total);
         end
      end

      // back pressure: every request yields a total while responses are held off
      write_size(CSR_ROW_COUNT, 11'd1);
      write_size(CSR_COLUMN_COUNT, 11'd1);
      long_hold_request = 1'b1;
      for (k = 0; k < 60; k++) begin
         send_element(draw_element(0), 1'b0, '0);
      end

      // largest sizes, reached through values above the limit, then abandoned
      write_size(CSR_ROW_COUNT, 11'd2047);
      write_size(CSR_COLUMN_COUNT, 11'd1025);
      for (k = 0; k < 40; k++) begin
         send_element(draw_element(1), 1'b0, '0);
      end

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: rows_data = '0;
            1: rows_data = SIZE_WIDTH'($urandom_range(6, 12));
            default: rows_data = SIZE_WIDTH'($urandom_range(1, 5));
         endcase
         case ($urandom_range(0, 9))
            0: cols_data = '0;
            1: cols_data = SIZE_WIDTH'($urandom_range(17, 48));
            default: cols_data = SIZE_WIDTH'($urandom_range(1, 16));
         endcase
         if ($urandom_range(0, 1) == 0) begin
            write_size(CSR_ROW_COUNT, rows_data);
            write_size(CSR_COLUMN_COUNT, cols_data);
         end else begin
            write_size(CSR_COLUMN_COUNT, cols_data);
            write_size(CSR_ROW_COUNT, rows_data);
         end
         steady_run = (random_items >= RANDOM_ITEMS - 150);
         calm_phase = ($urandom_range(0, 3) == 0);
         phase_matrices = $urandom_range(1, 4);
         for (m = 0; m < phase_matrices; m++) begin
            mode = $urandom_range(0, 3);
            send_matrix(mode);
            random_items += size_rows * size_cols;
         end
         // sometimes leave a matrix half done for the next write to abandon
         if (size_rows * size_cols > 1 && $urandom_range(0, 7) == 0) begin
            partial = $urandom_range(1, size_rows * size_cols - 1);
            mode = $urandom_range(0, 3);
            for (k = 0; k < partial; k++) begin
               send_element(draw_element(mode), 1'b0, '0);
            end
            random_items += partial;
         end
      end

      req_bus.valid = 1'b0;
      drain_wait = 0;
      while (expected_totals.size() != 0 && drain_wait < 20000) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (10) @(posedge clock);
      if (expected_totals.size() != 0) begin
         error_count += expected_totals.size();
         $display("ERROR %0d expected totals never arrived", expected_totals.size());
      end
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #5000000;
      $display("Verification failed");
      $finish;
   end

endmodule
